@@ rtl/core/pcsw_pkg.sv @@
package pcsw_pkg;

   // largest file the scan buffer covers
   localparam int unsigned MAX_FILE_BYTES = 4096;
   localparam int unsigned POS_W          = 13;

   localparam logic [POS_W-1:0] MAX_SIZE  = POS_W'(MAX_FILE_BYTES);
   localparam logic [31:0]      TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0]      TYPE_IEND = 32'h4945_4E44;
   localparam logic [31:0]      IHDR_LEN  = 32'd13;
   localparam logic [POS_W:0]   HDR_BYTES = (POS_W+1)'(12);
   localparam logic [POS_W-1:0] IHDR_TAIL = POS_W'(9);
   localparam logic [POS_W-1:0] CRC_BYTES = POS_W'(4);

   // eight signature bytes in file order
   localparam logic [7:0] SIG_BYTES [8] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };

   typedef enum logic [2:0] {
      PH_SIG,
      PH_HDR,
      PH_IHDR,
      PH_SKIP,
      PH_TAIL
   } phase_type;

   typedef enum logic [2:0] {
      ST_CHUNK    = 3'd0,
      ST_IHDR_OK  = 3'd1,
      ST_BAD_SIG  = 3'd2,
      ST_ESCAPE   = 3'd3,
      ST_IHDR_REJ = 3'd4,
      ST_IEND     = 3'd5,
      ST_NO_IEND  = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      chunk_tag;
      logic [31:0]      chunk_length;
      logic [POS_W-1:0] chunk_offset;
      logic [31:0]      image_width;
      logic [31:0]      image_height;
   } rsp_type;

endpackage

@@ rtl/core/png_chunk_stream_walker.sv @@
// channel | dir | handshake          | word
// req     | in  | req_valid/req_stall | pcsw_pkg::req_type (one file byte, restart flag)
// rsp     | out | rsp_valid/rsp_stall | pcsw_pkg::rsp_type (status and chunk fields)
// csr     | in  | csr_write          | file size, 13 bits
//
// one byte per cycle while req_stall is low; the whole per-byte update is one
// pass of logic from the input word into the scan registers and the result register
// a result is presented the cycle after the byte that causes it when the
// result buffer is empty, later when older results are still waiting
// a two-word result buffer keeps bytes flowing while a result waits; input
// stalls only when both result words are held
// synchronous reset clears the scan state, the file size and the result buffer
module png_chunk_stream_walker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  pcsw_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pcsw_pkg::rsp_type           rsp_data,
   input  logic                        csr_write,
   input  logic [pcsw_pkg::POS_W-1:0]  csr_wdata
);

   logic [pcsw_pkg::POS_W-1:0] size_ff;
   pcsw_pkg::phase_type        phase_ff, phase_in;
   logic [pcsw_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [3:0]                 fcount_ff, fcount_in;
   logic [31:0]                len_ff, len_in;
   logic [31:0]                ctype_ff, ctype_in;
   logic [31:0]                width_ff, width_in;
   logic [31:0]                height_ff, height_in;
   logic [pcsw_pkg::POS_W-1:0] skip_ff, skip_in;
   logic [pcsw_pkg::POS_W-1:0] hstart_ff, hstart_in;
   logic                       done_ff, done_in;

   logic [pcsw_pkg::POS_W-1:0] size_eff;
   logic                       req_take;
   logic                       rsp_take;
   logic                       fire;
   pcsw_pkg::status_type       status;
   pcsw_pkg::rsp_type          new_rsp;
   logic [7:0]                 b;

   pcsw_pkg::rsp_type          main_ff;
   pcsw_pkg::rsp_type          skid_ff;
   logic                       main_v_ff;
   logic                       skid_v_ff;

   // handshakes
   assign req_stall = skid_v_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = main_v_ff;
   assign rsp_data  = main_ff;
   assign rsp_take  = main_v_ff && !rsp_stall;

   assign size_eff = (size_ff > pcsw_pkg::MAX_SIZE) ? pcsw_pkg::MAX_SIZE : size_ff;
   assign b        = req_data.data_byte;

   // per-byte scan update
   always_comb begin
      if (req_data.first_byte) begin
         phase_in  = pcsw_pkg::PH_SIG;
         pos_in    = '0;
         fcount_in = '0;
         len_in    = '0;
         ctype_in  = '0;
         width_in  = '0;
         height_in = '0;
         skip_in   = '0;
         hstart_in = '0;
         done_in   = 1'b0;
      end else begin
         phase_in  = phase_ff;
         pos_in    = pos_ff;
         fcount_in = fcount_ff;
         len_in    = len_ff;
         ctype_in  = ctype_ff;
         width_in  = width_ff;
         height_in = height_ff;
         skip_in   = skip_ff;
         hstart_in = hstart_ff;
         done_in   = done_ff;
      end
      fire   = 1'b0;
      status = pcsw_pkg::ST_CHUNK;

      if (pos_in < size_eff) begin
         pos_in = pos_in + 1'b1;
         if (!done_in) begin
            case (phase_in)
               pcsw_pkg::PH_SIG: begin
                  if (b != pcsw_pkg::SIG_BYTES[pos_in[2:0] - 3'd1]) begin
                     fire    = 1'b1;
                     status  = pcsw_pkg::ST_BAD_SIG;
                     done_in = 1'b1;
                  end else if (pos_in >= pcsw_pkg::POS_W'(8)) begin
                     phase_in  = pcsw_pkg::PH_HDR;
                     fcount_in = '0;
                  end
               end
               pcsw_pkg::PH_HDR: begin
                  if (fcount_in == 4'd0 &&
                      {1'b0, pos_in - 1'b1} + pcsw_pkg::HDR_BYTES > {1'b0, size_eff}) begin
                     phase_in = pcsw_pkg::PH_TAIL;
                  end else begin
                     if (fcount_in == 4'd0) begin
                        hstart_in = pos_in - 1'b1;
                        len_in    = '0;
                        ctype_in  = '0;
                     end
                     if (fcount_in < 4'd4) begin
                        len_in = {len_in[23:0], b};
                     end else begin
                        ctype_in = {ctype_in[23:0], b};
                     end
                     fcount_in = fcount_in + 4'd1;
                     if (fcount_in >= 4'd8) begin
                        fcount_in = '0;
                        fire      = 1'b1;
                        if ({21'd0, hstart_in} + 34'd12 + {2'd0, len_in} >
                            {21'd0, size_eff}) begin
                           status  = pcsw_pkg::ST_ESCAPE;
                           done_in = 1'b1;
                        end else if (ctype_in == pcsw_pkg::TYPE_IEND) begin
                           status  = pcsw_pkg::ST_IEND;
                           done_in = 1'b1;
                        end else if (ctype_in == pcsw_pkg::TYPE_IHDR) begin
                           if (len_in != pcsw_pkg::IHDR_LEN) begin
                              status  = pcsw_pkg::ST_IHDR_REJ;
                              done_in = 1'b1;
                           end else begin
                              status   = pcsw_pkg::ST_CHUNK;
                              phase_in = pcsw_pkg::PH_IHDR;
                           end
                        end else begin
                           // length is bounded by the file size here
                           status   = pcsw_pkg::ST_CHUNK;
                           skip_in  = len_in[pcsw_pkg::POS_W-1:0] + pcsw_pkg::CRC_BYTES;
                           phase_in = pcsw_pkg::PH_SKIP;
                        end
                     end
                  end
               end
               pcsw_pkg::PH_IHDR: begin
                  if (fcount_in < 4'd4) begin
                     width_in = {(fcount_in == 4'd0) ? 24'd0 : width_in[23:0], b};
                  end else begin
                     height_in = {(fcount_in == 4'd4) ? 24'd0 : height_in[23:0], b};
                  end
                  fcount_in = fcount_in + 4'd1;
                  if (fcount_in >= 4'd8) begin
                     fcount_in = '0;
                     fire      = 1'b1;
                     if (width_in == 32'd0 || height_in == 32'd0) begin
                        status  = pcsw_pkg::ST_IHDR_REJ;
                        done_in = 1'b1;
                     end else begin
                        status   = pcsw_pkg::ST_IHDR_OK;
                        skip_in  = pcsw_pkg::IHDR_TAIL;
                        phase_in = pcsw_pkg::PH_SKIP;
                     end
                  end
               end
               pcsw_pkg::PH_SKIP: begin
                  if (skip_in != '0) begin
                     skip_in = skip_in - 1'b1;
                  end
                  if (skip_in == '0) begin
                     phase_in  = pcsw_pkg::PH_HDR;
                     fcount_in = '0;
                  end
               end
               default: begin
               end
            endcase

            // last byte of an unfinished scan
            if (!fire && !done_in && pos_in == size_eff) begin
               fire    = 1'b1;
               done_in = 1'b1;
               if (phase_in == pcsw_pkg::PH_SIG) begin
                  status = pcsw_pkg::ST_BAD_SIG;
               end else begin
                  status = pcsw_pkg::ST_NO_IEND;
               end
            end
         end
      end
   end

   // result word from the updated state
   always_comb begin
      new_rsp.status       = status;
      new_rsp.chunk_tag    = ctype_in;
      new_rsp.chunk_length = len_in;
      new_rsp.chunk_offset = hstart_in;
      new_rsp.image_width  = width_in;
      new_rsp.image_height = height_in;
   end

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_write) begin
         size_ff <= csr_wdata;
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= pcsw_pkg::PH_SIG;
         pos_ff    <= '0;
         fcount_ff <= '0;
         len_ff    <= '0;
         ctype_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         skip_ff   <= '0;
         hstart_ff <= '0;
         done_ff   <= 1'b0;
      end else if (req_take) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         fcount_ff <= fcount_in;
         len_ff    <= len_in;
         ctype_ff  <= ctype_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         skip_ff   <= skip_in;
         hstart_ff <= hstart_in;
         done_ff   <= done_in;
      end
   end

   // two-word result buffer, head word drives the port
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else if (!(req_take && fire)) begin
            main_v_ff <= 1'b0;
         end
      end else if (req_take && fire) begin
         if (!main_v_ff) begin
            main_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         if (skid_v_ff) begin
            main_ff <= skid_ff;
         end else if (req_take && fire) begin
            main_ff <= new_rsp;
         end
      end else if (req_take && fire) begin
         if (!main_v_ff) begin
            main_ff <= new_rsp;
         end else begin
            skid_ff <= new_rsp;
         end
      end
   end

`ifndef ASSERT_OFF
   // the second word is only ever behind a valid head word
   assert property (@(posedge clock) disable iff (reset) skid_v_ff |-> main_v_ff)
      else $error("result buffer holds a second word without a head word");

   // a finished scan stays finished until a restart byte comes in
   assert property (@(posedge clock) disable iff (reset)
      done_ff && !(req_take && req_data.first_byte) |=> done_ff)
      else $error("scan end flag dropped without a restart");

   // a full buffer with the head stalled keeps both words
   assert property (@(posedge clock) disable iff (reset)
      skid_v_ff && rsp_stall |=> skid_v_ff && main_v_ff)
      else $error("buffered result lost while stalled");

   // byte position never runs past the buffer size
   assert property (@(posedge clock) disable iff (reset) pos_ff <= pcsw_pkg::MAX_SIZE)
      else $error("byte position beyond buffer size");
`endif

endmodule
